/* rtl/core/lobm_pkg.sv */
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and constants of the limit order book matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;
	localparam int SYM_W = 4;
	localparam int QTY_W = 32;
	localparam int PRICE_W = 32;
	localparam int ID_W = 32;
	localparam int TOTAL_W = 37;
	localparam int STAMP_W = 64;
	localparam logic [ID_W-1:0] FIRST_ID_RESET = 32'd1;

	localparam logic SIDE_BUY = 1'b0;
	localparam logic SIDE_SELL = 1'b1;
	localparam logic KIND_FILL = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// one resting order as seen on the slot read port
	typedef struct packed {
		logic               valid;
		logic [SYM_W-1:0]   symbol;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   remaining;
		logic [ID_W-1:0]    order_id;
		logic [STAMP_W-1:0] stamp;
	} slot_t;

	// outcome of comparing one slot against the running best
	typedef struct packed {
		logic cand;
		logic take;
	} cmp_t;
endpackage
`default_nettype wire

/* rtl/core/lobm_cmp_unit.sv */
// ----------------------------------------------------------------------------
// lobm_cmp_unit
// Shared compare unit: checks one slot for crossing and price-time priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lobm_cmp_unit (
	input  wire lobm_pkg::slot_t                 slot,
	input  wire [lobm_pkg::SYM_W-1:0]   symbol,
	input  wire                         side,
	input  wire [lobm_pkg::PRICE_W-1:0] limit,
	input  wire                         found,
	input  wire [lobm_pkg::PRICE_W-1:0] best_price,
	input  wire [lobm_pkg::STAMP_W-1:0] best_stamp,
	output lobm_pkg::cmp_t              res
);
	logic crosses;
	logic better;
	logic older;

	always_comb begin
		if (side == lobm_pkg::SIDE_BUY) begin
			crosses = slot.price <= limit;
			better = slot.price < best_price;
		end else begin
			crosses = slot.price >= limit;
			better = slot.price > best_price;
		end
		older = (slot.price == best_price) && (slot.stamp < best_stamp);
		res.cand = slot.valid && (slot.symbol == symbol) && (slot.side != side) && crosses;
		res.take = res.cand && (!found || better || older);
	end
endmodule
`default_nettype wire

/* rtl/core/limit_order_book_matcher.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority limit order book over a bounded slot store.
// ----------------------------------------------------------------------------
// each run scans every slot before each fill, makes one fill per match, searches
// for a free slot and sums the book in a pass over every slot; a zero quantity
// skips the scans and the search; one slot per cycle through the shared compare
// unit, summary as busy falls
// one order per run; results cannot be stalled by the receiver
// reset clears the store and loads the next id with 1
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher #(
	parameter int ORDER_SLOTS = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire [lobm_pkg::SYM_W-1:0]          symbol_index,
	input  wire                                order_side,
	input  wire [lobm_pkg::QTY_W-1:0]          order_qty,
	input  wire [lobm_pkg::PRICE_W-1:0]        limit_price,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [lobm_pkg::ID_W-1:0]           cfg_data,
	output logic                               result_valid,
	output logic                               item_kind,
	output logic [lobm_pkg::ID_W-1:0]          maker_id,
	output logic [lobm_pkg::ID_W-1:0]          taker_id,
	output logic [lobm_pkg::QTY_W-1:0]         fill_qty,
	output logic [lobm_pkg::PRICE_W-1:0]       fill_price,
	output logic                               taker_side,
	output logic [lobm_pkg::QTY_W-1:0]         rested_qty,
	output logic [lobm_pkg::TOTAL_W-1:0]       bid_total,
	output logic [lobm_pkg::TOTAL_W-1:0]       ask_total,
	output logic                               book_full,
	output logic                               last_item
);
	localparam int IW = $clog2(ORDER_SLOTS);
	localparam int KW = $clog2(ORDER_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(ORDER_SLOTS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_REST  = 3'd3;
	localparam logic [2:0] ST_TOTAL = 3'd4;

	logic [2:0] state_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic found_q;
	logic [lobm_pkg::PRICE_W-1:0] best_price_q;
	logic [lobm_pkg::STAMP_W-1:0] best_stamp_q;
	logic [KW-1:0] k_q;
	logic [lobm_pkg::ID_W-1:0] next_id_q;
	logic [lobm_pkg::STAMP_W-1:0] arrival_q;

	logic [lobm_pkg::SYM_W-1:0] sym_q;
	logic side_q;
	logic [lobm_pkg::QTY_W-1:0] rem_q;
	logic [lobm_pkg::PRICE_W-1:0] limit_q;
	logic [lobm_pkg::ID_W-1:0] id_q;
	logic [lobm_pkg::QTY_W-1:0] rested_q;
	logic full_q;
	logic [lobm_pkg::TOTAL_W-1:0] bid_acc_q;
	logic [lobm_pkg::TOTAL_W-1:0] ask_acc_q;

	// slot store
	logic [ORDER_SLOTS-1:0] valid_q;
	logic [lobm_pkg::SYM_W-1:0] sym_mem [ORDER_SLOTS];
	logic side_mem [ORDER_SLOTS];
	logic [lobm_pkg::PRICE_W-1:0] price_mem [ORDER_SLOTS];
	logic [lobm_pkg::QTY_W-1:0] remain_mem [ORDER_SLOTS];
	logic [lobm_pkg::ID_W-1:0] id_mem [ORDER_SLOTS];
	logic [lobm_pkg::STAMP_W-1:0] stamp_mem [ORDER_SLOTS];

	logic [IW-1:0] rd_idx;
	lobm_pkg::slot_t rd_slot;
	lobm_pkg::cmp_t cmp;
	logic [lobm_pkg::QTY_W-1:0] trade_qty;
	logic [KW-1:0] k_inc;
	logic accept;

	assign busy = state_q != ST_IDLE;
	// an order offered in the same cycle goes first
	assign cfg_ready = !busy && !start;
	assign accept = start && !busy;
	assign rd_idx = (state_q == ST_FILL) ? best_q : idx_q;
	assign k_inc = k_q + KW'(1);

	always_comb begin
		rd_slot.valid = valid_q[rd_idx];
		rd_slot.symbol = sym_mem[rd_idx];
		rd_slot.side = side_mem[rd_idx];
		rd_slot.price = price_mem[rd_idx];
		rd_slot.remaining = remain_mem[rd_idx];
		rd_slot.order_id = id_mem[rd_idx];
		rd_slot.stamp = stamp_mem[rd_idx];
		trade_qty = (rem_q < rd_slot.remaining) ? rem_q : rd_slot.remaining;
	end

	lobm_cmp_unit u_cmp (
		.slot       (rd_slot),
		.symbol     (sym_q),
		.side       (side_q),
		.limit      (limit_q),
		.found      (found_q),
		.best_price (best_price_q),
		.best_stamp (best_stamp_q),
		.res        (cmp)
	);

	// store payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL) begin
			remain_mem[best_q] <= rd_slot.remaining - trade_qty;
		end
		if (state_q == ST_REST && rem_q != '0 && !valid_q[idx_q]) begin
			sym_mem[idx_q] <= sym_q;
			side_mem[idx_q] <= side_q;
			price_mem[idx_q] <= limit_q;
			remain_mem[idx_q] <= rem_q;
			id_mem[idx_q] <= id_q;
			stamp_mem[idx_q] <= arrival_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			next_id_q <= lobm_pkg::FIRST_ID_RESET;
			arrival_q <= '0;
			result_valid <= 1'b0;
			idx_q <= '0;
			best_q <= '0;
			found_q <= 1'b0;
			k_q <= '0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						next_id_q <= next_id_q + 32'd1;
						idx_q <= '0;
						found_q <= 1'b0;
						k_q <= '0;
						state_q <= (order_qty != '0) ? ST_SCAN : ST_REST;
					end else if (cfg_valid && cfg_ready) begin
						next_id_q <= cfg_data;
					end
				end
				ST_SCAN: begin
					if (cmp.take) begin
						found_q <= 1'b1;
						best_q <= idx_q;
					end
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						state_q <= (found_q || cmp.take) ? ST_FILL : ST_REST;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_FILL: begin
					result_valid <= 1'b1;
					if (rd_slot.remaining == trade_qty) begin
						valid_q[best_q] <= 1'b0;
					end
					k_q <= k_inc;
					found_q <= 1'b0;
					idx_q <= '0;
					if (rem_q != trade_qty && k_inc < KW'(ORDER_SLOTS)) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_REST;
					end
				end
				ST_REST: begin
					if (rem_q == '0) begin
						idx_q <= '0;
						state_q <= ST_TOTAL;
					end else if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						arrival_q <= arrival_q + 64'd1;
						idx_q <= '0;
						state_q <= ST_TOTAL;
					end else if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						state_q <= ST_TOTAL;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_TOTAL: begin
					if (idx_q == LAST_IDX) begin
						result_valid <= 1'b1;
						idx_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// order context and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sym_q <= symbol_index;
					side_q <= order_side;
					rem_q <= order_qty;
					limit_q <= limit_price;
					id_q <= next_id_q;
					rested_q <= '0;
					full_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (cmp.take) begin
					best_price_q <= rd_slot.price;
					best_stamp_q <= rd_slot.stamp;
				end
			end
			ST_FILL: begin
				rem_q <= rem_q - trade_qty;
				item_kind <= lobm_pkg::KIND_FILL;
				maker_id <= rd_slot.order_id;
				taker_id <= id_q;
				fill_qty <= trade_qty;
				fill_price <= rd_slot.price;
				taker_side <= side_q;
				rested_qty <= '0;
				bid_total <= '0;
				ask_total <= '0;
				book_full <= 1'b0;
				last_item <= 1'b0;
			end
			ST_REST: begin
				bid_acc_q <= '0;
				ask_acc_q <= '0;
				if (rem_q != '0 && !valid_q[idx_q]) begin
					rested_q <= rem_q;
				end else if (rem_q != '0 && idx_q == LAST_IDX) begin
					full_q <= 1'b1;
				end
			end
			ST_TOTAL: begin
				logic [lobm_pkg::TOTAL_W-1:0] bid_n;
				logic [lobm_pkg::TOTAL_W-1:0] ask_n;
				bid_n = bid_acc_q;
				ask_n = ask_acc_q;
				if (rd_slot.valid && rd_slot.symbol == sym_q) begin
					if (rd_slot.side == lobm_pkg::SIDE_BUY) begin
						bid_n = bid_acc_q + lobm_pkg::TOTAL_W'(rd_slot.remaining);
					end else begin
						ask_n = ask_acc_q + lobm_pkg::TOTAL_W'(rd_slot.remaining);
					end
				end
				bid_acc_q <= bid_n;
				ask_acc_q <= ask_n;
				if (idx_q == LAST_IDX) begin
					item_kind <= lobm_pkg::KIND_SUMMARY;
					maker_id <= '0;
					taker_id <= id_q;
					fill_qty <= '0;
					fill_price <= '0;
					taker_side <= side_q;
					rested_qty <= rested_q;
					bid_total <= bid_n;
					ask_total <= ask_n;
					book_full <= full_q;
					last_item <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// the summary transaction always ends a run
	a_end_summary: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && last_item)
		else $error("run ended without summary");

	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && item_kind == lobm_pkg::KIND_FILL |-> busy && fill_qty != '0)
		else $error("fill outside a run or empty");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted order did not start a run");

	a_rest_or_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_item |-> !(book_full && rested_qty != '0))
		else $error("rested and full together");
endmodule
`default_nettype wire

/* test/tb_limit_order_book_matcher.sv */
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher
// Drives limit orders and id register writes into the matcher, keeps its own
// price-time priority book to predict every fill and summary item, and checks
// each strobed result in order against the predicted stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_limit_order_book_matcher;

	localparam int SLOTS = 32;
	localparam int STALL_LIMIT = 6000;

	typedef struct packed {
		logic                         kind;
		logic [lobm_pkg::ID_W-1:0]    maker;
		logic [lobm_pkg::ID_W-1:0]    taker;
		logic [lobm_pkg::QTY_W-1:0]   qty;
		logic [lobm_pkg::PRICE_W-1:0] price;
		logic                         side;
		logic [lobm_pkg::QTY_W-1:0]   rested;
		logic [lobm_pkg::TOTAL_W-1:0] bids;
		logic [lobm_pkg::TOTAL_W-1:0] asks;
		logic                         full;
		logic                         last;
	} book_item_t;

	class book_scoreboard;
		bit                           live[SLOTS];
		bit [lobm_pkg::SYM_W-1:0]     sym[SLOTS];
		bit                           sd[SLOTS];
		bit [lobm_pkg::PRICE_W-1:0]   px[SLOTS];
		bit [lobm_pkg::QTY_W-1:0]     left[SLOTS];
		bit [lobm_pkg::ID_W-1:0]      oid[SLOTS];
		longint unsigned              stamp[SLOTS];
		longint unsigned              arrivals;
		bit [lobm_pkg::ID_W-1:0]      next_id;
		book_item_t                   due[$];
		int                           errors;

		function new();
			next_id = lobm_pkg::FIRST_ID_RESET;
			arrivals = 0;
			errors = 0;
			foreach (live[i]) live[i] = 0;
		endfunction

		function void load_first_id(bit [lobm_pkg::ID_W-1:0] v);
			next_id = v;
		endfunction

		function bit [lobm_pkg::TOTAL_W-1:0] resting(bit [lobm_pkg::SYM_W-1:0] s, bit side);
			bit [lobm_pkg::TOTAL_W-1:0] n;
			n = '0;
			for (int i = 0; i < SLOTS; i++)
				if (live[i] && sym[i] == s && sd[i] == side)
					n += left[i];
			return n;
		endfunction

		function int best_maker(bit [lobm_pkg::SYM_W-1:0] s, bit side,
				bit [lobm_pkg::PRICE_W-1:0] lim);
			int b;
			bit better;
			b = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (!live[i] || sym[i] != s || sd[i] == side)
					continue;
				if (side == lobm_pkg::SIDE_BUY ? (px[i] > lim) : (px[i] < lim))
					continue;
				if (b < 0) begin
					b = i;
				end else begin
					better = side == lobm_pkg::SIDE_BUY ? (px[i] < px[b]) : (px[i] > px[b]);
					if (better || (px[i] == px[b] && stamp[i] < stamp[b]))
						b = i;
				end
			end
			return b;
		endfunction

		function void note_order(bit [lobm_pkg::SYM_W-1:0] s, bit side,
				bit [lobm_pkg::QTY_W-1:0] q, bit [lobm_pkg::PRICE_W-1:0] lim);
			bit [lobm_pkg::QTY_W-1:0] rem;
			bit [lobm_pkg::QTY_W-1:0] t;
			bit [lobm_pkg::ID_W-1:0] id;
			int fills;
			int m;
			int fs;
			book_item_t it;
			rem = q;
			id = next_id;
			next_id = next_id + 1;
			fills = 0;
			while (rem > 0 && fills < SLOTS) begin
				m = best_maker(s, side, lim);
				if (m < 0)
					break;
				t = rem < left[m] ? rem : left[m];
				left[m] -= t;
				rem -= t;
				it = '0;
				it.kind = lobm_pkg::KIND_FILL;
				it.maker = oid[m];
				it.taker = id;
				it.qty = t;
				it.price = px[m];
				it.side = side;
				due.insert(due.size(), it);
				fills++;
				if (left[m] == 0)
					live[m] = 0;
			end
			it = '0;
			if (rem > 0) begin
				fs = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!live[i] && fs < 0)
						fs = i;
				if (fs < 0) begin
					it.full = 1;
				end else begin
					live[fs] = 1;
					sym[fs] = s;
					sd[fs] = side;
					px[fs] = lim;
					left[fs] = rem;
					oid[fs] = id;
					stamp[fs] = arrivals;
					arrivals++;
					it.rested = rem;
				end
			end
			it.kind = lobm_pkg::KIND_SUMMARY;
			it.taker = id;
			it.side = side;
			it.bids = resting(s, lobm_pkg::SIDE_BUY);
			it.asks = resting(s, lobm_pkg::SIDE_SELL);
			it.last = 1;
			due.insert(due.size(), it);
		endfunction

		function void field(string n, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $realtime, n, e, a);
				errors++;
			end
		endfunction

		function void check_result(book_item_t a);
			book_item_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %p", $realtime, a);
				errors++;
				return;
			end
			e = due.pop_front();
			field("item_kind", e.kind, a.kind);
			field("maker_id", e.maker, a.maker);
			field("taker_id", e.taker, a.taker);
			field("fill_qty", e.qty, a.qty);
			field("fill_price", e.price, a.price);
			field("taker_side", e.side, a.side);
			field("rested_qty", e.rested, a.rested);
			field("bid_total", e.bids, a.bids);
			field("ask_total", e.asks, a.asks);
			field("book_full", e.full, a.full);
			field("last_item", e.last, a.last);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [lobm_pkg::SYM_W-1:0] symbol_index = '0;
	logic order_side = 0;
	logic [lobm_pkg::QTY_W-1:0] order_qty = '0;
	logic [lobm_pkg::PRICE_W-1:0] limit_price = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [lobm_pkg::ID_W-1:0] cfg_data = '0;
	logic result_valid;
	logic res_kind;
	logic [lobm_pkg::ID_W-1:0] res_maker;
	logic [lobm_pkg::ID_W-1:0] res_taker;
	logic [lobm_pkg::QTY_W-1:0] res_qty;
	logic [lobm_pkg::PRICE_W-1:0] res_price;
	logic res_side;
	logic [lobm_pkg::QTY_W-1:0] res_rested;
	logic [lobm_pkg::TOTAL_W-1:0] res_bids;
	logic [lobm_pkg::TOTAL_W-1:0] res_asks;
	logic res_full;
	logic res_last;
	book_item_t res;

	book_scoreboard sb = new();
	int idle_cycles = 0;
	int burst_left = 0;

	assign res = {res_kind, res_maker, res_taker, res_qty, res_price, res_side,
		res_rested, res_bids, res_asks, res_full, res_last};

	limit_order_book_matcher #(.ORDER_SLOTS(SLOTS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.symbol_index(symbol_index), .order_side(order_side),
		.order_qty(order_qty), .limit_price(limit_price),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .item_kind(res_kind), .maker_id(res_maker),
		.taker_id(res_taker), .fill_qty(res_qty), .fill_price(res_price),
		.taker_side(res_side), .rested_qty(res_rested), .bid_total(res_bids),
		.ask_total(res_asks), .book_full(res_full), .last_item(res_last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(res);
		if ((arst_n && result_valid) || (start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_first_id(bit [lobm_pkg::ID_W-1:0] v);
		@(negedge clk);
		cfg_valid = 1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		sb.load_first_id(v);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// ends any burst so no order is offered while the book settles
	task automatic drain();
		@(negedge clk);
		start = 0;
		burst_left = 0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one order transaction; start stays high through a burst
	task automatic send_order(bit [lobm_pkg::SYM_W-1:0] s, bit side,
			bit [lobm_pkg::QTY_W-1:0] q, bit [lobm_pkg::PRICE_W-1:0] p);
		@(negedge clk);
		if (burst_left == 0) begin
			if (start) begin
				start = 0;
				repeat ($urandom_range(1, 25)) @(negedge clk);
			end
			burst_left = $urandom_range(0, 3) == 0 ? 12 : $urandom_range(1, 5);
		end
		start = 1;
		symbol_index = s;
		order_side = side;
		order_qty = q;
		limit_price = p;
		do @(posedge clk); while (busy);
		sb.note_order(s, side, q, p);
		burst_left--;
	endtask

	task automatic random_order();
		bit [lobm_pkg::SYM_W-1:0] s;
		bit side;
		bit [lobm_pkg::QTY_W-1:0] q;
		bit [lobm_pkg::PRICE_W-1:0] p;
		int r;
		r = $urandom_range(0, 31);
		s = $urandom_range(0, 7) == 0 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
		side = 1'($urandom_range(0, 1));
		q = $urandom_range(1, 60);
		p = $urandom_range(90, 110);
		if (r == 0) begin
			// sweep that clears the opposite side of a symbol
			q = 32'hffff_ffff;
			p = side == lobm_pkg::SIDE_BUY ? 32'hffff_ffff : 32'h0;
		end else if (r < 3) begin
			q = $urandom();
		end else if (r < 5) begin
			p = $urandom();
		end else if (r == 5) begin
			q = 0;
		end
		send_order(s, side, q, p);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, full store, multi-fill sweep, zero quantity
		send_order(4'd15, lobm_pkg::SIDE_BUY, 32'hffff_ffff, 32'hffff_ffff);
		send_order(4'd15, lobm_pkg::SIDE_SELL, 32'hffff_ffff, 32'h0);
		send_order(4'd15, lobm_pkg::SIDE_SELL, 32'h0, 32'h5);
		send_order(4'd0, lobm_pkg::SIDE_SELL, 32'd10, 32'hffff_ffff);
		send_order(4'd0, lobm_pkg::SIDE_BUY, 32'd4, 32'hffff_fffe);
		send_order(4'd0, lobm_pkg::SIDE_BUY, 32'd25, 32'hffff_ffff);
		drain();
		write_first_id(32'hffff_fffd);
		for (int i = 0; i < 8; i++)
			send_order(4'd5, lobm_pkg::SIDE_BUY, 32'd3, 32'd10 + (i % 3));
		send_order(4'd5, lobm_pkg::SIDE_SELL, 32'd7, 32'd11);
		send_order(4'd6, lobm_pkg::SIDE_SELL, 32'd2, 32'd1);
		drain();
		write_first_id(32'h0);
		for (int i = 0; i < 36; i++)
			send_order(4'd9, lobm_pkg::SIDE_SELL, 32'd1, 32'd50 + (i % 4));
		send_order(4'd9, lobm_pkg::SIDE_BUY, 32'd100, 32'hffff_ffff);
		send_order(4'd3, lobm_pkg::SIDE_SELL, 32'd1, 32'd0);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			write_first_id(ph == 2 ? 32'hffff_ffff : $urandom());
			for (int n = 0; n < 135; n++)
				random_order();
			drain();
		end

		@(negedge clk);
		start = 0;
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire
